FILE: sv/swpm_pkg.sv
package swpm_pkg;

  // Defaults for the top level parameters.
  localparam int unsigned PATTERN_MAX_DEF = 16;
  localparam int unsigned ELEM_WIDTH_DEF  = 32;
  localparam int unsigned TEXT_MAX_DEF    = 65536;

  // Fixed field widths.
  localparam int unsigned ElemPortW = 32;
  localparam int unsigned IdxW      = 4;
  localparam int unsigned PosW      = 16;
  localparam int unsigned LenW      = 5;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = LenW;

  // Command codes.
  localparam logic CMD_PATTERN = 1'b0;
  localparam logic CMD_TEXT    = 1'b1;

  // Result kinds.
  localparam logic KIND_MATCH     = 1'b0;
  localparam logic KIND_NOT_FOUND = 1'b1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_PATTERN_LENGTH = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_STRING_MODE    = 1'b1;

  typedef struct packed {
    logic                 is_text;
    logic [IdxW-1:0]      pattern_index;
    logic [ElemPortW-1:0] elem_value;
    logic                 text_last;
  } op_t;

  typedef struct packed {
    logic [LenW-1:0] pattern_length;
    logic            string_mode;
  } cfg_t;

  typedef struct packed {
    logic            kind;
    logic [PosW-1:0] position;
    logic            overflow;
  } res_t;

endpackage

FILE: sv/swpm_fifo.sv
module swpm_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q[1];
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop) rd_ptr_q <= !rd_ptr_q;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

FILE: sv/swpm_front.sv
module swpm_front
  import swpm_pkg::*;
#(
  parameter int unsigned PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic                 command_i,
  input  logic [IdxW-1:0]      pattern_index_i,
  input  logic [ElemPortW-1:0] elem_value_i,
  input  logic                 text_last_i,
  output logic                 op_valid_o,
  output op_t                  op_o,
  input  logic                 op_pop_i
);

  op_t  op_in;
  logic keep;
  logic op_empty;

  // Pattern writes to a slot past the store are dropped here.
  assign keep = (command_i == CMD_TEXT) || (32'(pattern_index_i) < PATTERN_MAX);

  always_comb begin
    op_in.is_text       = (command_i == CMD_TEXT);
    op_in.pattern_index = pattern_index_i;
    op_in.elem_value    = elem_value_i;
    op_in.text_last     = text_last_i;
  end

  swpm_fifo #(
    .WIDTH($bits(op_t))
  ) u_op_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push && keep),
    .data_i (op_in),
    .full_o (full),
    .pop_i  (op_pop_i),
    .data_o (op_o),
    .empty_o(op_empty)
  );

  assign op_valid_o = !op_empty;

endmodule

FILE: sv/swpm_back.sv
module swpm_back
  import swpm_pkg::*;
#(
  parameter int unsigned PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int unsigned ELEM_WIDTH  = ELEM_WIDTH_DEF,
  parameter int unsigned TEXT_MAX    = TEXT_MAX_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic op_valid_i,
  input  op_t  op_i,
  output logic op_pop_o,
  input  cfg_t cfg_i,
  output logic empty,
  input  logic pop,
  output res_t res_o
);

  localparam int unsigned StoreW = (ELEM_WIDTH < ElemPortW) ? ELEM_WIDTH : ElemPortW;
  localparam int unsigned CntW   = $clog2(TEXT_MAX + 1);
  localparam logic [CntW-1:0] TextMaxC = CntW'(TEXT_MAX);

  logic [StoreW-1:0] pattern_q [PATTERN_MAX];
  logic [StoreW-1:0] window_q  [PATTERN_MAX];
  logic [StoreW-1:0] window_d  [PATTERN_MAX];
  logic [StoreW-1:0] sel_w     [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] eq_w;
  logic [CntW-1:0] count_q, count_d, cnt_inc;
  logic seen_q, seen_d, ovf_q, ovf_d;
  logic res_full, go, saturated, shift_en, len_ok, hit;
  logic [31:0] cmp_len;
  res_t res_d;
  logic res_push;

  assign go        = op_valid_i && !res_full;
  assign op_pop_o  = go;
  assign saturated = (count_q == TextMaxC);
  assign shift_en  = go && op_i.is_text && !saturated;
  assign cnt_inc   = count_q + CntW'(1);

  always_comb begin
    window_d[0] = op_i.elem_value[StoreW-1:0];
    for (int k = 1; k < PATTERN_MAX; k++) begin
      window_d[k] = window_q[k-1];
    end
  end

  // Window slot m-1-j lines up with pattern slot j.
  always_comb begin
    cmp_len = cfg_i.string_mode ? (32'(cfg_i.pattern_length) - 32'd1)
                                : 32'(cfg_i.pattern_length);
    for (int j = 0; j < PATTERN_MAX; j++) begin
      sel_w[j] = '0;
      for (int k = 0; k < PATTERN_MAX; k++) begin
        if (32'(cfg_i.pattern_length) == 32'(j + k + 1)) sel_w[j] = window_d[k];
      end
      eq_w[j] = !(32'(j) < cmp_len) || (sel_w[j] == pattern_q[j]);
    end
  end

  assign len_ok = (cfg_i.pattern_length != '0)
               && (32'(cfg_i.pattern_length) <= PATTERN_MAX)
               && (32'(cnt_inc) >= 32'(cfg_i.pattern_length))
               && !(cfg_i.string_mode && (32'(cfg_i.pattern_length) < 32'd2));
  assign hit = shift_en && len_ok && (&eq_w);

  always_comb begin
    count_d  = count_q;
    seen_d   = seen_q;
    ovf_d    = ovf_q;
    res_push = 1'b0;
    res_d.kind     = KIND_MATCH;
    res_d.position = PosW'(cnt_inc - CntW'(cfg_i.pattern_length));
    res_d.overflow = ovf_q || saturated;
    if (go && op_i.is_text) begin
      if (saturated) begin
        ovf_d = 1'b1;
      end else begin
        count_d = cnt_inc;
      end
      if (hit) begin
        seen_d   = 1'b1;
        res_push = 1'b1;
      end else if (op_i.text_last && !seen_q) begin
        res_push       = 1'b1;
        res_d.kind     = KIND_NOT_FOUND;
        res_d.position = '0;
      end
      if (op_i.text_last) begin
        count_d = '0;
        seen_d  = 1'b0;
        ovf_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      seen_q  <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      seen_q  <= seen_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
        window_q[k] <= window_d[k];
      end
    end
    if (go && !op_i.is_text) begin
      for (int s = 0; s < PATTERN_MAX; s++) begin
        if (32'(op_i.pattern_index) == 32'(s)) begin
          pattern_q[s] <= op_i.elem_value[StoreW-1:0];
        end
      end
    end
  end

  swpm_fifo #(
    .WIDTH($bits(res_t))
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_d),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_o),
    .empty_o(empty)
  );

endmodule

FILE: sv/sliding_window_pattern_matcher.sv
// Path: a request waits in the input queue, then the window compare takes it and
// writes any result to the result queue, which feeds the result ports.
// Throughput: one request per cycle while the result queue is not full.
// Stalls: a full result queue holds the back end, which then fills the input queue.
// Reset: asynchronous, active low; clears the queues, the text count and flags, and
// sets pattern_length to 1 and string_mode to 0. The pattern store is not cleared.
module sliding_window_pattern_matcher
  import swpm_pkg::*;
#(
  parameter int unsigned PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int unsigned ELEM_WIDTH  = ELEM_WIDTH_DEF,
  parameter int unsigned TEXT_MAX    = TEXT_MAX_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic                 command_i,
  input  logic [IdxW-1:0]      pattern_index_i,
  input  logic [ElemPortW-1:0] elem_value_i,
  input  logic                 text_last_i,
  output logic                 empty,
  input  logic                 pop,
  output logic                 kind_o,
  output logic [PosW-1:0]      position_o,
  output logic                 overflow_o,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  cfg_t cfg_q;
  op_t  op;
  logic op_valid, op_pop;
  res_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern_length <= LenW'(1);
      cfg_q.string_mode    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PATTERN_LENGTH: cfg_q.pattern_length <= cfg_data_i[LenW-1:0];
        CFG_STRING_MODE:    cfg_q.string_mode    <= cfg_data_i[0];
        default:            cfg_q                <= cfg_q;
      endcase
    end
  end

  swpm_front #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .command_i      (command_i),
    .pattern_index_i(pattern_index_i),
    .elem_value_i   (elem_value_i),
    .text_last_i    (text_last_i),
    .op_valid_o     (op_valid),
    .op_o           (op),
    .op_pop_i       (op_pop)
  );

  swpm_back #(
    .PATTERN_MAX(PATTERN_MAX),
    .ELEM_WIDTH (ELEM_WIDTH),
    .TEXT_MAX   (TEXT_MAX)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_valid_i(op_valid),
    .op_i      (op),
    .op_pop_o  (op_pop),
    .cfg_i     (cfg_q),
    .empty     (empty),
    .pop       (pop),
    .res_o     (res)
  );

  assign kind_o     = res.kind;
  assign position_o = res.position;
  assign overflow_o = res.overflow;

endmodule
